@@ design/ptq_pkg.sv @@
// Shared types and constants for the periodic timer queue.
// Used by ptq_slot_mem, ptq_scan and periodic_timer_queue; depends on nothing.
package ptq_pkg;

   localparam int MAX_TIMERS = 16;
   localparam int IDX_W      = $clog2(MAX_TIMERS);
   localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

   localparam int FUNC_W = 2;
   localparam int TIME_W = 48;
   localparam int IVAL_W = 32;
   localparam int ID_W   = 16;

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] deadline;
      logic [IVAL_W-1:0] interval;
   } slot_type;

   // one scan step: slot data arrives alongside this from the slot memory
   typedef struct packed {
      logic            clear;
      logic            step;
      logic            slot_valid;
      idx_type         idx;
      logic [ID_W-1:0] key;
   } scan_ctl_type;

   typedef struct packed {
      logic     best_found;
      idx_type  best_idx;
      slot_type best_slot;
      logic     match_found;
      idx_type  match_idx;
   } scan_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_REM_SCAN,
      ST_TICK_SCAN,
      ST_FIN_SCAN
   } state_type;

endpackage

@@ design/ptq_slot_mem.sv @@
// Timer slot store: id, deadline and interval per slot, one write and one read port.
// Read data is registered. Depends on ptq_pkg.
module ptq_slot_mem (
   input  logic             clock,
   input  logic             wr_en,
   input  ptq_pkg::idx_type  wr_addr,
   input  ptq_pkg::slot_type wr_data,
   input  logic             rd_en,
   input  ptq_pkg::idx_type  rd_addr,
   output ptq_pkg::slot_type rd_data
);
   import ptq_pkg::*;

   slot_type mem_ff [MAX_TIMERS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ptq_scan.sv @@
// Shared scan unit: one slot per step, tracks the earliest deadline (lowest slot on ties)
// and the first slot whose id matches the key. Depends on ptq_pkg.
module ptq_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  ptq_pkg::scan_ctl_type ctl,
   input  ptq_pkg::slot_type     slot,
   output ptq_pkg::scan_res_type res
);
   import ptq_pkg::*;

   logic     best_found_ff, best_found_in;
   idx_type  best_idx_ff, best_idx_in;
   slot_type best_slot_ff, best_slot_in;
   logic     match_found_ff, match_found_in;
   idx_type  match_idx_ff, match_idx_in;

   logic take_best;
   logic take_match;

   always_comb begin
      // strict less-than keeps the lower slot on equal deadlines
      take_best  = ctl.step && ctl.slot_valid &&
                   (!best_found_ff || (slot.deadline < best_slot_ff.deadline));
      take_match = ctl.step && ctl.slot_valid && !match_found_ff && (slot.id == ctl.key);

      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_slot_in   = best_slot_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      if (ctl.clear) begin
         best_found_in  = 1'b0;
         match_found_in = 1'b0;
      end else begin
         if (take_best) begin
            best_found_in = 1'b1;
            best_idx_in   = ctl.idx;
            best_slot_in  = slot;
         end
         if (take_match) begin
            match_found_in = 1'b1;
            match_idx_in   = ctl.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff  <= 1'b0;
         match_found_ff <= 1'b0;
      end else begin
         best_found_ff  <= best_found_in;
         match_found_ff <= match_found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_slot_ff <= best_slot_in;
      match_idx_ff <= match_idx_in;
   end

   assign res.best_found  = best_found_ff;
   assign res.best_idx    = best_idx_ff;
   assign res.best_slot   = best_slot_ff;
   assign res.match_found = match_found_ff;
   assign res.match_idx   = match_idx_ff;

endmodule

@@ design/periodic_timer_queue.sv @@
// Periodic timer queue: sequencer, slot valid bits and result registers.
// Instantiates ptq_slot_mem and ptq_scan; depends on ptq_pkg.
//
// An item is taken when start is high and busy low; busy then stays high until the
// result has been formed. Every item walks the whole slot table one slot per cycle
// through the single read port of the slot memory. Remove and tick take two scans; an
// add on a full table and the unused code take one; an add takes one scan per id
// candidate tried plus the final scan, so usually two, at most MAX_TIMERS + 2 when
// candidate ids collide with live ones or wrap to zero. The result appears in the
// cycle after the last scan, with rsp_strobe high for exactly that cycle, which is
// also the first cycle a new item can be taken. The receiver cannot stall: sample
// the rsp_ fields while rsp_strobe is high, they are only held until a new item is
// taken.
module periodic_timer_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ptq_pkg::FUNC_W-1:0]   req_func,
   input  logic [ptq_pkg::TIME_W-1:0]   req_start_time,
   input  logic [ptq_pkg::IVAL_W-1:0]   req_interval,
   input  logic [ptq_pkg::ID_W-1:0]     req_timer_id,
   input  logic [ptq_pkg::TIME_W-1:0]   req_now_time,
   input  logic                         req_handler_stop,
   output logic                         rsp_strobe,
   output logic [ptq_pkg::ID_W-1:0]     rsp_new_id,
   output logic                         rsp_add_failed,
   output logic                         rsp_fired,
   output logic [ptq_pkg::ID_W-1:0]     rsp_fired_id,
   output logic                         rsp_armed,
   output logic [ptq_pkg::TIME_W-1:0]   rsp_next_deadline
);
   import ptq_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_pend_ff;
   idx_type               rd_idx_ff;
   logic [MAX_TIMERS-1:0] valid_ff, valid_in;
   logic [ID_W-1:0]       last_id_ff, last_id_in;
   logic                  strobe_ff;

   logic [ID_W-1:0]   cand_ff;
   logic [ID_W-1:0]   key_ff;
   idx_type           free_idx_ff;
   logic [TIME_W-1:0] start_ff;
   logic [IVAL_W-1:0] ival_ff;
   logic [TIME_W-1:0] now_ff;
   logic              stop_ff;

   logic [ID_W-1:0]   new_id_ff;
   logic              add_failed_ff;
   logic              fired_ff;
   logic [ID_W-1:0]   fired_id_ff;
   logic              armed_ff;
   logic [TIME_W-1:0] next_dl_ff;

   logic accept;
   logic table_full;
   idx_type free_idx;
   logic scan_done;
   logic rd_issue;
   logic scan_restart;
   logic add_retry;
   logic add_ok;
   logic rem_hit;
   logic tick_fire;
   logic tick_rearm;
   logic fin_done;

   logic              wr_en;
   idx_type           wr_addr;
   slot_type          wr_data;
   slot_type          rd_data;
   logic [TIME_W:0]   rearm_sum;
   logic [TIME_W-1:0] rearm_dl;

   scan_ctl_type scan_ctl;
   scan_res_type scan_res;

   ptq_slot_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_issue),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   ptq_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .slot  (rd_data),
      .res   (scan_res)
   );

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = idx_type'(i);
         end
      end
   end

   assign table_full = &valid_ff;
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign scan_done  = (cnt_ff == CNT_W'(MAX_TIMERS)) && !rd_pend_ff;

   // rearm: now plus interval, saturated to the time width
   assign rearm_sum = {1'b0, now_ff} + {{(TIME_W + 1 - IVAL_W){1'b0}}, scan_res.best_slot.interval};
   assign rearm_dl  = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_ADD:    state_in = table_full ? ST_FIN_SCAN : ST_ADD_SCAN;
                  FUNC_REMOVE: state_in = ST_REM_SCAN;
                  FUNC_TICK:   state_in = ST_TICK_SCAN;
                  default:     state_in = ST_FIN_SCAN;
               endcase
            end
         end
         ST_ADD_SCAN: begin
            if (scan_done && !add_retry) state_in = ST_FIN_SCAN;
         end
         ST_REM_SCAN, ST_TICK_SCAN: begin
            if (scan_done) state_in = ST_FIN_SCAN;
         end
         ST_FIN_SCAN: begin
            if (scan_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      rd_issue   = busy && (cnt_ff != CNT_W'(MAX_TIMERS));
      add_retry  = (state_ff == ST_ADD_SCAN) && scan_done &&
                   ((cand_ff == '0) || scan_res.match_found);
      add_ok     = (state_ff == ST_ADD_SCAN) && scan_done && !add_retry;
      rem_hit    = (state_ff == ST_REM_SCAN) && scan_done && scan_res.match_found;
      tick_fire  = (state_ff == ST_TICK_SCAN) && scan_done && scan_res.best_found &&
                   (scan_res.best_slot.deadline <= now_ff);
      tick_rearm = tick_fire && (scan_res.best_slot.interval != '0) && !stop_ff;
      fin_done   = (state_ff == ST_FIN_SCAN) && scan_done;
      scan_restart = accept || (scan_done && ((state_ff == ST_ADD_SCAN) ||
                     (state_ff == ST_REM_SCAN) || (state_ff == ST_TICK_SCAN)));

      cnt_in = cnt_ff;
      if (scan_restart) begin
         cnt_in = '0;
      end else if (rd_issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      wr_en = add_ok || tick_rearm;
      if (add_ok) begin
         wr_addr          = free_idx_ff;
         wr_data.id       = cand_ff;
         wr_data.deadline = start_ff;
         wr_data.interval = ival_ff;
      end else begin
         wr_addr          = scan_res.best_idx;
         wr_data.id       = scan_res.best_slot.id;
         wr_data.deadline = rearm_dl;
         wr_data.interval = scan_res.best_slot.interval;
      end

      valid_in = valid_ff;
      if (add_ok) valid_in[free_idx_ff] = 1'b1;
      if (rem_hit) valid_in[scan_res.match_idx] = 1'b0;
      if (tick_fire && !tick_rearm) valid_in[scan_res.best_idx] = 1'b0;

      last_id_in = add_ok ? cand_ff : last_id_ff;

      scan_ctl.clear      = scan_restart;
      scan_ctl.step       = rd_pend_ff;
      scan_ctl.slot_valid = valid_ff[rd_idx_ff];
      scan_ctl.idx        = rd_idx_ff;
      scan_ctl.key        = (state_ff == ST_ADD_SCAN) ? cand_ff : key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
         rd_idx_ff  <= '0;
         valid_ff   <= '0;
         last_id_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= rd_issue;
         rd_idx_ff  <= cnt_ff[IDX_W-1:0];
         valid_ff   <= valid_in;
         last_id_ff <= last_id_in;
         strobe_ff  <= fin_done;
      end
   end

   // request word and result fields
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff        <= req_timer_id;
         start_ff      <= req_start_time;
         ival_ff       <= req_interval;
         now_ff        <= req_now_time;
         stop_ff       <= req_handler_stop;
         free_idx_ff   <= free_idx;
         cand_ff       <= last_id_ff + ID_W'(1);
         new_id_ff     <= '0;
         add_failed_ff <= (req_func == FUNC_ADD) && table_full;
         fired_ff      <= 1'b0;
         fired_id_ff   <= '0;
      end
      if (add_retry) cand_ff <= cand_ff + ID_W'(1);
      if (add_ok) new_id_ff <= cand_ff;
      if (tick_fire) begin
         fired_ff    <= 1'b1;
         fired_id_ff <= scan_res.best_slot.id;
      end
      if (fin_done) begin
         armed_ff   <= scan_res.best_found;
         next_dl_ff <= scan_res.best_found ? scan_res.best_slot.deadline : '0;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_new_id        = new_id_ff;
   assign rsp_add_failed    = add_failed_ff;
   assign rsp_fired         = fired_ff;
   assign rsp_fired_id      = fired_id_ff;
   assign rsp_armed         = armed_ff;
   assign rsp_next_deadline = next_dl_ff;

   a_strobe_after_final: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_FIN_SCAN))
      else $error("result strobe without a finished final scan");

   a_add_free_slot: assert property (@(posedge clock) disable iff (reset)
      add_ok |-> !valid_ff[free_idx_ff])
      else $error("add would overwrite a live slot");

   a_unarmed_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_armed) |-> (valid_ff == '0))
      else $error("reported unarmed while slots are live");

   a_fire_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_fired) |-> ((rsp_new_id == '0) && !rsp_add_failed))
      else $error("fired result carries add fields");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after taking a word");

endmodule
